>>> hdl/bci_pkg.sv
package bci_pkg;

  localparam int unsigned FracShift = 24;
  localparam int unsigned QuotBits  = 32;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_V0_POS = 3'd0,
    REG_V1_POS = 3'd1,
    REG_V2_POS = 3'd2,
    REG_V0_FLD = 3'd3,
    REG_V1_FLD = 3'd4,
    REG_V2_FLD = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_first;
    logic signed [31:0] weight_second;
    logic signed [31:0] weight_third;
    logic               inside_res;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic               degenerate;
  } out_item_t;

  // Side information that rides along with an item through the divider
  typedef struct packed {
    logic [2:0] neg;
    logic       in_tri;
    logic       degen;
  } tag_t;

endpackage

>>> hdl/bci_det.sv
module bci_det #(
  parameter int unsigned CW = 32,
  parameter int unsigned DW = 2 * CW + 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  input  logic signed [CW-1:0] vx_i [3],
  input  logic signed [CW-1:0] vy_i [3],
  output logic                 valid_o,
  output logic [DW-1:0]        mag_a_o,
  output logic [DW-1:0]        mag_s_o [3],
  output bci_pkg::tag_t        tag_o
);

  localparam int unsigned PW = 2 * CW + 2;

  logic signed [CW:0] x0, y0, x1, y1, x2, y2, pxe, pye;
  logic signed [CW:0] diff_d [10];
  logic signed [CW:0] diff_q [10];
  logic signed [PW-1:0] prod_d [8];
  logic signed [PW-1:0] prod_q [8];
  logic signed [DW-1:0] det_d [4];
  logic signed [DW-1:0] det_q [4];
  logic [DW-1:0] mag_d [4];
  logic [DW-1:0] mag_q [4];
  logic [3:0] sgn;
  bci_pkg::tag_t tag_d, tag_q;
  logic [3:0] vld_q;

  assign x0  = (CW+1)'(vx_i[0]);
  assign y0  = (CW+1)'(vy_i[0]);
  assign x1  = (CW+1)'(vx_i[1]);
  assign y1  = (CW+1)'(vy_i[1]);
  assign x2  = (CW+1)'(vx_i[2]);
  assign y2  = (CW+1)'(vy_i[2]);
  assign pxe = (CW+1)'(px_i);
  assign pye = (CW+1)'(py_i);

  always_comb begin
    diff_d[0] = x1 - x0;
    diff_d[1] = y1 - y0;
    diff_d[2] = x2 - x0;
    diff_d[3] = y2 - y0;
    diff_d[4] = x1 - pxe;
    diff_d[5] = y1 - pye;
    diff_d[6] = x2 - pxe;
    diff_d[7] = y2 - pye;
    diff_d[8] = pxe - x0;
    diff_d[9] = pye - y0;
  end

  // Area term, then the three sub-areas with the point swapped in
  always_comb begin
    prod_d[0] = PW'(diff_q[0] * diff_q[3]);
    prod_d[1] = PW'(diff_q[2] * diff_q[1]);
    prod_d[2] = PW'(diff_q[4] * diff_q[7]);
    prod_d[3] = PW'(diff_q[6] * diff_q[5]);
    prod_d[4] = PW'(diff_q[8] * diff_q[3]);
    prod_d[5] = PW'(diff_q[2] * diff_q[9]);
    prod_d[6] = PW'(diff_q[0] * diff_q[9]);
    prod_d[7] = PW'(diff_q[8] * diff_q[1]);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      det_d[k] = DW'(prod_q[2*k]) - DW'(prod_q[2*k+1]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sgn[k]   = det_q[k][DW-1];
      mag_d[k] = sgn[k] ? DW'(-det_q[k]) : DW'(det_q[k]);
    end
    tag_d.degen  = (det_q[0] == '0);
    tag_d.in_tri = 1'b1;
    for (int k = 0; k < 3; k++) begin
      tag_d.neg[k] = sgn[k+1] ^ sgn[0];
      if (!((det_q[k+1] == '0) || (!tag_d.neg[k] && (mag_d[0] >= mag_d[k+1])))) begin
        tag_d.in_tri = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
      det_q  <= det_d;
      mag_q  <= mag_d;
      tag_q  <= tag_d;
    end
  end

  assign valid_o    = vld_q[3];
  assign mag_a_o    = mag_q[0];
  assign mag_s_o[0] = mag_q[1];
  assign mag_s_o[1] = mag_q[2];
  assign mag_s_o[2] = mag_q[3];
  assign tag_o      = tag_q;

endmodule

>>> hdl/bci_div.sv
module bci_div #(
  parameter int unsigned DW = 67
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DW-1:0]          d_i,
  input  logic [DW-1:0]          n_i [3],
  input  bci_pkg::tag_t          tag_i,
  output logic                   valid_o,
  output logic [bci_pkg::QuotBits-1:0] q_o [3],
  output logic [2:0]             ovf_o,
  output bci_pkg::tag_t          tag_o
);

  localparam int unsigned Steps = bci_pkg::QuotBits;
  localparam int unsigned QW    = bci_pkg::QuotBits;
  // numerator is |det| shifted up by FracShift; all but the low QW bits of it start the remainder
  localparam int unsigned PreSh = QW - bci_pkg::FracShift;

  logic [DW-1:0] r_q   [Steps+1][3];
  logic [QW-1:0] q_q   [Steps+1][3];
  logic [QW-1:0] lo_q  [Steps+1][3];
  logic [DW-1:0] d_q   [Steps+1];
  logic [2:0]    ovf_q [Steps+1];
  bci_pkg::tag_t tag_q [Steps+1];
  logic [Steps:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]   <= d_i;
      tag_q[0] <= tag_i;
      for (int l = 0; l < 3; l++) begin
        r_q[0][l]    <= n_i[l] >> PreSh;
        lo_q[0][l]   <= {n_i[l][PreSh-1:0], {bci_pkg::FracShift{1'b0}}};
        q_q[0][l]    <= '0;
        ovf_q[0][l]  <= ((n_i[l] >> PreSh) >= d_i);
      end
    end
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [DW:0]   rs [3];
    logic [2:0]    ge;
    logic [DW-1:0] rn [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rs[l] = {r_q[s-1][l], lo_q[s-1][l][QW-1]};
        ge[l] = (rs[l] >= {1'b0, d_q[s-1]});
        rn[l] = ge[l] ? DW'(rs[l] - {1'b0, d_q[s-1]}) : DW'(rs[l]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]   <= d_q[s-1];
        tag_q[s] <= tag_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        for (int l = 0; l < 3; l++) begin
          r_q[s][l]  <= rn[l];
          q_q[s][l]  <= {q_q[s-1][l][QW-2:0], ge[l]};
          lo_q[s][l] <= {lo_q[s-1][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign q_o     = q_q[Steps];
  assign ovf_o   = ovf_q[Steps];
  assign tag_o   = tag_q[Steps];

endmodule

>>> hdl/bci_blend.sv
module bci_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [31:0]          q_i [3],
  input  logic [2:0]           ovf_i,
  input  bci_pkg::tag_t        tag_i,
  input  logic signed [31:0]   fld_x_i [3],
  input  logic signed [31:0]   fld_y_i [3],
  output logic                 valid_o,
  output bci_pkg::out_item_t   data_o
);

  localparam int unsigned SW = 66;
  localparam int unsigned HW = SW - bci_pkg::FracShift;

  logic signed [31:0] w_d [3];
  logic signed [31:0] wa_q [3];
  logic signed [31:0] wb_q [3];
  logic               ins_a_q, deg_a_q, ins_b_q, deg_b_q;
  logic signed [63:0] px_d [3];
  logic signed [63:0] py_d [3];
  logic signed [63:0] px_q [3];
  logic signed [63:0] py_q [3];
  logic signed [SW-1:0] sx, sy;
  logic [HW-1:0] hx, hy;
  logic signed [31:0] fx, fy;
  bci_pkg::out_item_t out_d, out_q;
  logic [2:0] vld_q;

  // Apply sign and clamp to the Q8.24 range
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!tag_i.neg[l]) begin
        w_d[l] = (ovf_i[l] || q_i[l][31]) ? 32'sh7fffffff : $signed(q_i[l]);
      end else begin
        w_d[l] = (ovf_i[l] || (q_i[l][31] && (|q_i[l][30:0]))) ? 32'sh80000000
                                                                 : $signed(-q_i[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      px_d[l] = 64'(wa_q[l]) * 64'(fld_x_i[l]);
      py_d[l] = 64'(wa_q[l]) * 64'(fld_y_i[l]);
    end
  end

  always_comb begin
    sx = SW'(1 << (bci_pkg::FracShift - 1)) + SW'(px_q[0]) + SW'(px_q[1]) + SW'(px_q[2]);
    sy = SW'(1 << (bci_pkg::FracShift - 1)) + SW'(py_q[0]) + SW'(py_q[1]) + SW'(py_q[2]);
    hx = sx[SW-1:bci_pkg::FracShift];
    hy = sy[SW-1:bci_pkg::FracShift];
    if ((&hx[HW-1:31]) || !(|hx[HW-1:31])) begin
      fx = $signed(hx[31:0]);
    end else begin
      fx = hx[HW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end
    if ((&hy[HW-1:31]) || !(|hy[HW-1:31])) begin
      fy = $signed(hy[31:0]);
    end else begin
      fy = hy[HW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end
    out_d = '0;
    if (deg_b_q) begin
      out_d.degenerate = 1'b1;
    end else begin
      out_d.weight_first  = wb_q[0];
      out_d.weight_second = wb_q[1];
      out_d.weight_third  = wb_q[2];
      out_d.inside_res    = ins_b_q;
      out_d.field_x       = fx;
      out_d.field_y       = fy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q    <= w_d;
      ins_a_q <= tag_i.in_tri;
      deg_a_q <= tag_i.degen;
      wb_q    <= wa_q;
      ins_b_q <= ins_a_q;
      deg_b_q <= deg_a_q;
      px_q    <= px_d;
      py_q    <= py_d;
      out_q   <= out_d;
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = out_q;

endmodule

>>> hdl/triangle_barycentric_interpolator.sv
// Pipeline: 4 determinant stages, 1 + 32 divider stages and 3 blend stages
//   between input transaction and result.
// Throughput: one transaction per cycle; the restoring divider is fully pipelined
//   at one quotient bit per stage. The whole pipeline holds while a result waits.
// Reset: rst_ni clears all valid bits and the six configuration registers to zero.
module triangle_barycentric_interpolator #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bci_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bci_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bci_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);

  localparam int unsigned CW = COORD_WIDTH;
  // exact 3x3 determinant width: two (CW+1)-bit products and a difference
  localparam int unsigned DW = 2 * CW + 3;

  logic [63:0] pos_q [3];
  logic [63:0] fld_q [3];

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [31:0]   fx [3];
  logic signed [31:0]   fy [3];

  logic en;

  logic          det_valid;
  logic [DW-1:0] det_mag_a;
  logic [DW-1:0] det_mag_s [3];
  bci_pkg::tag_t det_tag;

  logic          div_valid;
  logic [31:0]   div_q [3];
  logic [2:0]    div_ovf;
  bci_pkg::tag_t div_tag;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '{default: '0};
      fld_q <= '{default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bci_pkg::cfg_reg_e'(cfg_index_i))
        bci_pkg::REG_V0_POS: pos_q[0] <= cfg_data_i;
        bci_pkg::REG_V1_POS: pos_q[1] <= cfg_data_i;
        bci_pkg::REG_V2_POS: pos_q[2] <= cfg_data_i;
        bci_pkg::REG_V0_FLD: fld_q[0] <= cfg_data_i;
        bci_pkg::REG_V1_FLD: fld_q[1] <= cfg_data_i;
        bci_pkg::REG_V2_FLD: fld_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Positions use the low COORD_WIDTH bits of each half, sign extended
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      vx[v] = $signed(pos_q[v][32 +: CW]);
      vy[v] = $signed(pos_q[v][CW-1:0]);
      fx[v] = $signed(fld_q[v][63:32]);
      fy[v] = $signed(fld_q[v][31:0]);
    end
  end

  // Global advance: the pipeline moves unless a finished result is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  bci_det #(
    .CW (CW),
    .DW (DW)
  ) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .px_i    ($signed(in_data_i.point_x[CW-1:0])),
    .py_i    ($signed(in_data_i.point_y[CW-1:0])),
    .vx_i    (vx),
    .vy_i    (vy),
    .valid_o (det_valid),
    .mag_a_o (det_mag_a),
    .mag_s_o (det_mag_s),
    .tag_o   (det_tag)
  );

  bci_div #(
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .d_i     (det_mag_a),
    .n_i     (det_mag_s),
    .tag_i   (det_tag),
    .valid_o (div_valid),
    .q_o     (div_q),
    .ovf_o   (div_ovf),
    .tag_o   (div_tag)
  );

  bci_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .q_i     (div_q),
    .ovf_i   (div_ovf),
    .tag_i   (div_tag),
    .fld_x_i (fx),
    .fld_y_i (fy),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // A stall toward the source only comes from a held result
  a_stall_from_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Zero-area triangle gives all-zero payload
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.weight_first == '0 && out_data_o.weight_second == '0 &&
       out_data_o.weight_third == '0 && !out_data_o.inside_res &&
       out_data_o.field_x == '0 && out_data_o.field_y == '0))
    else $error("degenerate result with nonzero payload");

  // Inside point: every weight within zero and one in Q8.24
  a_inside_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.inside_res) |->
      (!out_data_o.degenerate &&
       out_data_o.weight_first >= 0 && out_data_o.weight_first <= 32'sh01000000 &&
       out_data_o.weight_second >= 0 && out_data_o.weight_second <= 32'sh01000000 &&
       out_data_o.weight_third >= 0 && out_data_o.weight_third <= 32'sh01000000))
    else $error("inside flag with weight out of range");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DrainWait = 50;   // a margin past the pipeline depth
  localparam int unsigned StallLim  = 5000; // cycles without any transaction

  // Reference of the barycentric datapath plus the queue of pending weights
  class weight_scoreboard;
    logic [63:0]        regs[6];
    bci_pkg::out_item_t pending_weights[$];
    int unsigned mismatches;
    int unsigned matched;
    int unsigned degen_seen;
    int unsigned inside_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
      matched = 0;
      degen_seen = 0;
      inside_seen = 0;
    endfunction

    function automatic logic signed [127:0] coord(logic [31:0] v);
      logic signed [31:0] t;
      t = v << (32 - CoordW);
      t = t >>> (32 - CoordW);
      return 128'(t);
    endfunction

    function automatic logic signed [127:0] sat32(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return 128'sh7FFF_FFFF;
      if (v < -128'sh8000_0000) return -128'sh8000_0000;
      return v;
    endfunction

    function automatic logic signed [127:0] area(
        logic signed [127:0] ax, logic signed [127:0] ay,
        logic signed [127:0] bx, logic signed [127:0] by,
        logic signed [127:0] cx, logic signed [127:0] cy);
      return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    endfunction

    function automatic logic signed [127:0] ratio(logic signed [127:0] ai,
                                                  logic signed [127:0] a);
      logic signed [127:0] n, d, q;
      n = (ai < 0) ? -ai : ai;
      d = (a < 0) ? -a : a;
      q = (n <<< bci_pkg::FracShift) / d;
      if ((ai < 0) != (a < 0)) q = -q;
      return sat32(q);
    endfunction

    function automatic bci_pkg::out_item_t barycentric(bci_pkg::in_item_t pt);
      logic signed [127:0] vx[3], vy[3], fx[3], fy[3], s[3], w[3];
      logic signed [127:0] a, px, py, bx, by, absa, abss;
      bci_pkg::out_item_t r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
        vx[i] = coord(regs[i][63:32]);
        vy[i] = coord(regs[i][31:0]);
        fx[i] = 128'($signed(regs[3 + i][63:32]));
        fy[i] = 128'($signed(regs[3 + i][31:0]));
      end
      px = coord(pt.point_x);
      py = coord(pt.point_y);
      a = area(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
      if (a == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      s[0] = area(px, py, vx[1], vy[1], vx[2], vy[2]);
      s[1] = area(vx[0], vy[0], px, py, vx[2], vy[2]);
      s[2] = area(vx[0], vy[0], vx[1], vy[1], px, py);
      r.inside_res = 1'b1;
      absa = (a < 0) ? -a : a;
      for (int i = 0; i < 3; i++) begin
        w[i] = ratio(s[i], a);
        abss = (s[i] < 0) ? -s[i] : s[i];
        // inside is decided on exact determinants, not rounded weights
        if (s[i] != 0 && (((s[i] < 0) != (a < 0)) || abss > absa))
          r.inside_res = 1'b0;
      end
      r.weight_first  = w[0][31:0];
      r.weight_second = w[1][31:0];
      r.weight_third  = w[2][31:0];
      bx = 128'sd1 <<< 23;
      by = 128'sd1 <<< 23;
      for (int i = 0; i < 3; i++) begin
        bx = bx + w[i] * fx[i];
        by = by + w[i] * fy[i];
      end
      r.field_x = 32'(sat32(bx >>> bci_pkg::FracShift));
      r.field_y = 32'(sat32(by >>> bci_pkg::FracShift));
      return r;
    endfunction

    function void note_point(bci_pkg::in_item_t pt);
      pending_weights.push_back(barycentric(pt));
    endfunction

    function void note_reg(logic [bci_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
      if (idx < 6) regs[idx] = data;
    endfunction

    function bit cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(bci_pkg::out_item_t act);
      bci_pkg::out_item_t e;
      bit bad;
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        mismatches++;
        return;
      end
      e = pending_weights.pop_front();
      bad = 1'b0;
      bad |= cmp("weight_first",  e.weight_first,  act.weight_first);
      bad |= cmp("weight_second", e.weight_second, act.weight_second);
      bad |= cmp("weight_third",  e.weight_third,  act.weight_third);
      bad |= cmp("inside_res",    32'(e.inside_res), 32'(act.inside_res));
      bad |= cmp("field_x",       e.field_x,       act.field_x);
      bad |= cmp("field_y",       e.field_y,       act.field_y);
      bad |= cmp("degenerate",    32'(e.degenerate), 32'(act.degenerate));
      if (bad) mismatches++;
      else matched++;
      if (e.degenerate) degen_seen++;
      if (e.inside_res) inside_seen++;
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  bci_pkg::in_item_t            in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  bci_pkg::out_item_t           out_data_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [bci_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [63:0]                  cfg_data_i = '0;

  weight_scoreboard sb = new();
  bit               calm = 1'b0;  // suppress idling on both sides
  int unsigned      quiet_cycles = 0;
  int unsigned      points_sent = 0;
  int unsigned      phase_count = 0;

  triangle_barycentric_interpolator #(.COORD_WIDTH(CoordW)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor all three channels at the edge; stalls are driven nonblocking so
  // the values read here are the ones that held during the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_point(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (cfg_valid_i && cfg_ready_o) sb.note_reg(cfg_index_i, cfg_data_i);
    end
  end

  // Receiver backpressure: stall with a chance of about 35 in 100 unless calm
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  // Watchdog on cycles where no transaction moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLim) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.pending_weights.size());
        $display("triangle_barycentric_interpolator verification failed");
        $finish;
      end
    end
  end

  // Write all six registers back to back; valid drops only after the last one
  task automatic load_triangle(logic [63:0] v0, logic [63:0] v1, logic [63:0] v2,
                               logic [63:0] f0, logic [63:0] f1, logic [63:0] f2);
    logic [63:0] vals[6];
    bci_pkg::cfg_reg_e r;
    vals = '{v0, v1, v2, f0, f1, f2};
    r = r.first();
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      r = r.next();
    end
    cfg_valid_i <= 1'b0;
    phase_count++;
  endtask

  // Hold off until the pipeline has delivered every outstanding result
  task automatic drain();
    while (sb.pending_weights.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 35) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{point_x: x, point_y: y};
    do @(posedge clk_i); while (in_stall_o);
    points_sent++;
  endtask

  function automatic logic [31:0] near(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [63:0] pack_xy(logic [31:0] x, logic [31:0] y);
    return {x, y};
  endfunction

  // Mostly points scattered around the origin, some fully random
  task automatic random_points(int unsigned n, int unsigned span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) send_point(near(span), near(span));
      else send_point($urandom, $urandom);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic random_triangle(int unsigned span, bit full_field);
    logic [63:0] f[3];
    for (int i = 0; i < 3; i++)
      f[i] = full_field ? {$urandom, $urandom} : pack_xy(near(1 << 22), near(1 << 22));
    load_triangle(pack_xy(near(span), near(span)), pack_xy(near(span), near(span)),
                  pack_xy(near(span), near(span)), f[0], f[1], f[2]);
  endtask

  localparam logic [31:0] Ten  = 32'd10 << 16;
  localparam logic [31:0] Five = 32'd5 << 16;
  localparam logic [31:0] MaxC = 32'h7FFF_FFFF;
  localparam logic [31:0] MinC = 32'h8000_0000;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset: zero area, every point degenerate
    send_point(32'd0, 32'd0);
    send_point(MaxC, MinC);
    send_point($urandom, $urandom);
    in_valid_i <= 1'b0;
    drain();

    // Right triangle (0,0) (10,0) (0,10): vertices, edges, centroid, outside
    load_triangle(pack_xy(0, 0), pack_xy(Ten, 0), pack_xy(0, Ten),
                  pack_xy(32'h0001_0000, 32'hFFFF_0000),
                  pack_xy(32'h7FFF_FFFF, 32'h8000_0000),
                  pack_xy(32'h0003_8000, 32'h0000_0001));
    send_point(0, 0);
    send_point(Ten, 0);
    send_point(0, Ten);
    send_point(Five, 0);
    send_point(Five, Five);
    send_point(0, Five);
    send_point(32'h0003_5555, 32'h0003_5555);
    send_point(Ten + 1, 0);
    send_point(32'hFFFF_FFFF, 32'd1);
    send_point(MaxC, MaxC);
    send_point(MinC, MinC);
    send_point(MaxC, MinC);
    send_point(MinC, MaxC);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    in_valid_i <= 1'b0;
    drain();

    // Long stretch without any idling on either side
    calm = 1'b1;
    random_triangle(1 << 21, 1'b0);
    random_points(120, 1 << 21);
    drain();
    calm = 1'b0;

    random_triangle(1 << 21, 1'b0);
    random_points(150, 1 << 21);
    drain();

    // Coordinate and field extremes: widest determinants, saturated blends
    load_triangle(pack_xy(MinC, MinC), pack_xy(MaxC, MinC), pack_xy(MinC, MaxC),
                  pack_xy(MaxC, MinC), pack_xy(MinC, MaxC), pack_xy(MaxC, MaxC));
    random_points(100, 32'h7FFF_FFFF);
    drain();

    // Collinear vertices: nonzero registers, still zero area
    load_triangle(pack_xy(Five, Five), pack_xy(Ten, Ten), pack_xy(0, 0),
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    random_points(40, 1 << 21);
    drain();

    random_triangle(1 << 24, 1'b1);
    random_points(150, 1 << 24);
    drain();

    random_triangle(1 << 18, 1'b1);
    random_points(150, 1 << 18);
    drain();

    $display("Covered %0d points over %0d register settings: %0d results checked clean,",
             points_sent, phase_count, sb.matched);
    $display("  %0d degenerate and %0d inside-triangle results among them.",
             sb.degen_seen, sb.inside_seen);
    if (sb.mismatches == 0 && sb.pending_weights.size() == 0) begin
      $display("triangle_barycentric_interpolator verification clean");
    end else begin
      $display("triangle_barycentric_interpolator verification failed");
    end
    $finish;
  end

endmodule
